FILE: rtl/btprl_pkg.sv
`default_nettype none

package btprl_pkg;

   // Payload and register widths.
   localparam int POS_W      = 63;
   localparam int TIME_W     = 63;
   localparam int TWIN_W     = 48;
   localparam int PWIN_W     = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Register select, taken from address bit 3 (registers sit 8 bytes apart).
   localparam logic REG_TIME_WINDOW     = 1'b0;
   localparam logic REG_POSITION_WINDOW = 1'b1;

   localparam logic [TWIN_W-1:0] TIME_WINDOW_RESET     = 48'd34359738368;
   localparam logic [PWIN_W-1:0] POSITION_WINDOW_RESET = 32'd1048576;

   // What the datapath puts on the result ports at the end of a cycle.
   typedef enum logic [1:0] {
      RSP_IDLE,
      RSP_ZERO,
      RSP_PUSH,
      RSP_LOOKUP
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         seg_first;
      logic         seg_second;
      logic         probe;
      logic         step;
      logic         commit;
      logic         clear;
      rsp_kind_type rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic seg_open;
      logic seg_hit;
      logic wrapped;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/btprl_ram.sv
`default_nettype none

module btprl_ram #(
   parameter int WIDTH = 126,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/btprl_csr.sv
`default_nettype none

module btprl_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [btprl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [btprl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [btprl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                      pready,
   output logic      [btprl_pkg::TWIN_W-1:0]         time_window,
   output logic      [btprl_pkg::PWIN_W-1:0]         position_window
);

   logic [btprl_pkg::TWIN_W-1:0] twin_ff, twin_in;
   logic [btprl_pkg::PWIN_W-1:0] pwin_ff, pwin_in;
   logic                         sel;
   logic                         wr_en;

   // Registers are 8 bytes apart; only the select bit is decoded.
   assign sel    = paddr[btprl_pkg::CSR_ADDR_W-1];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      twin_in = twin_ff;
      pwin_in = pwin_ff;
      if (wr_en) begin
         case (sel)
            btprl_pkg::REG_TIME_WINDOW: begin
               twin_in = pwdata[btprl_pkg::TWIN_W-1:0];
            end
            btprl_pkg::REG_POSITION_WINDOW: begin
               pwin_in = pwdata[btprl_pkg::PWIN_W-1:0];
            end
            default: begin
               twin_in = twin_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (sel)
         btprl_pkg::REG_TIME_WINDOW:     prdata = btprl_pkg::CSR_DATA_W'(twin_ff);
         btprl_pkg::REG_POSITION_WINDOW: prdata = btprl_pkg::CSR_DATA_W'(pwin_ff);
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twin_ff <= btprl_pkg::TIME_WINDOW_RESET;
         pwin_ff <= btprl_pkg::POSITION_WINDOW_RESET;
      end else begin
         twin_ff <= twin_in;
         pwin_ff <= pwin_in;
      end
   end

   assign time_window     = twin_ff;
   assign position_window = pwin_ff;

endmodule

`default_nettype wire

FILE: rtl/btprl_ctrl.sv
`default_nettype none

module btprl_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [btprl_pkg::CMD_W-1:0]   command,
   input  wire btprl_pkg::dp_status_type      status,
   output btprl_pkg::dp_cmd_type              cmd,
   output logic                               busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_DIFF,
      ST_PUSH_COMMIT,
      ST_SEARCH_TEST,
      ST_SEARCH_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp  = btprl_pkg::RSP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (command)
                  btprl_pkg::CMD_PUSH: begin
                     cmd.load = 1'b1;
                     state_in = ST_PUSH_DIFF;
                  end
                  btprl_pkg::CMD_LOOKUP: begin
                     cmd.load      = 1'b1;
                     cmd.seg_first = 1'b1;
                     state_in      = ST_SEARCH_TEST;
                  end
                  btprl_pkg::CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.rsp   = btprl_pkg::RSP_ZERO;
                  end
                  default: begin
                     cmd.rsp = btprl_pkg::RSP_ZERO;
                  end
               endcase
            end
         end
         ST_PUSH_DIFF: begin
            state_in = ST_PUSH_COMMIT;
         end
         ST_PUSH_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.rsp    = btprl_pkg::RSP_PUSH;
            state_in   = ST_IDLE;
         end
         ST_SEARCH_TEST: begin
            if (status.seg_open) begin
               cmd.probe = 1'b1;
               state_in  = ST_SEARCH_CMP;
            end else if (!status.seg_hit && status.wrapped) begin
               cmd.seg_second = 1'b1;
            end else begin
               cmd.rsp  = btprl_pkg::RSP_LOOKUP;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH_CMP: begin
            cmd.step = 1'b1;
            state_in = ST_SEARCH_TEST;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

FILE: rtl/btprl_dp.sv
`default_nettype none

module btprl_dp #(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire btprl_pkg::dp_cmd_type              cmd,
   output btprl_pkg::dp_status_type                status,
   input  wire logic [btprl_pkg::POS_W-1:0]        req_entry_position,
   input  wire logic [btprl_pkg::TIME_W-1:0]       req_time_value,
   input  wire logic [btprl_pkg::TIME_W-1:0]       req_current_time,
   input  wire logic [btprl_pkg::POS_W-1:0]        req_reference_position,
   input  wire logic [btprl_pkg::TWIN_W-1:0]       time_window,
   input  wire logic [btprl_pkg::PWIN_W-1:0]       position_window,
   output logic                                    rsp_valid,
   output logic      [btprl_pkg::POS_W-1:0]        rsp_found_position,
   output logic                                    rsp_found,
   output logic                                    rsp_accepted
);

   localparam int IW = $clog2(RING_DEPTH);
   // Search bounds run from -1 up to RING_DEPTH, kept modulo 2**SW.
   localparam int SW = IW + 2;
   localparam int MW = btprl_pkg::POS_W + btprl_pkg::TIME_W;
   localparam logic [IW-1:0] LAST = IW'(RING_DEPTH - 1);

   logic [btprl_pkg::POS_W-1:0]  epos_ff, epos_in;
   logic [btprl_pkg::TIME_W-1:0] tval_ff, tval_in;
   logic [btprl_pkg::TIME_W-1:0] ctime_ff, ctime_in;
   logic [btprl_pkg::POS_W-1:0]  rpos_ff, rpos_in;
   logic [btprl_pkg::TIME_W-1:0] tdiff_ff, tdiff_in;
   logic [btprl_pkg::POS_W-1:0]  pdiff_ff, pdiff_in;
   logic [IW-1:0]                read_ff, read_in;
   logic [IW-1:0]                write_ff, write_in;
   logic [SW-1:0]                a_ff, a_in;
   logic [SW-1:0]                b_ff, b_in;
   logic [SW-1:0]                hi_ff, hi_in;
   logic                         wrapped_ff, wrapped_in;
   logic [IW-1:0]                c_ff, c_in;
   logic [btprl_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [btprl_pkg::POS_W-1:0]  rsp_fpos_ff, rsp_fpos_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         rsp_acc_ff, rsp_acc_in;

   logic [SW-1:0]                span;
   logic [SW-1:0]                sum;
   logic [IW-1:0]                mid;
   logic                         hit;
   logic                         push_ok;
   logic [IW-1:0]                write_next;
   logic [IW-1:0]                read_next;
   logic                         ram_we;
   logic [IW-1:0]                ram_addr;
   logic [MW-1:0]                ram_rdata;
   logic [btprl_pkg::TIME_W-1:0] rd_time;
   logic [btprl_pkg::POS_W-1:0]  rd_pos;

   assign span = b_ff - a_ff;
   assign sum  = a_ff + b_ff;
   assign mid  = sum[IW:1];
   assign hit  = (b_ff != hi_ff);

   assign push_ok = (tdiff_ff <= btprl_pkg::TIME_W'(time_window)) &&
                    (pdiff_ff <= btprl_pkg::POS_W'(position_window));

   assign write_next = (write_ff == LAST) ? '0 : write_ff + 1'b1;
   assign read_next  = (read_ff == LAST) ? '0 : read_ff + 1'b1;

   assign rd_time = ram_rdata[btprl_pkg::TIME_W-1:0];
   assign rd_pos  = ram_rdata[btprl_pkg::TIME_W +: btprl_pkg::POS_W];

   assign ram_we   = cmd.commit && push_ok;
   assign ram_addr = cmd.commit ? write_ff : mid;

   assign status.seg_open = (span > SW'(1));
   assign status.seg_hit  = hit;
   assign status.wrapped  = wrapped_ff;

   always_comb begin
      epos_in      = epos_ff;
      tval_in      = tval_ff;
      ctime_in     = ctime_ff;
      rpos_in      = rpos_ff;
      read_in      = read_ff;
      write_in     = write_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      hi_in        = hi_ff;
      wrapped_in   = wrapped_ff;
      c_in         = c_ff;
      pos_in       = pos_ff;
      rsp_fpos_in  = '0;
      rsp_found_in = 1'b0;
      rsp_acc_in   = 1'b0;
      rsp_valid_in = (cmd.rsp != btprl_pkg::RSP_IDLE);

      tdiff_in = (tval_ff >= ctime_ff) ? tval_ff - ctime_ff : ctime_ff - tval_ff;
      pdiff_in = (epos_ff >= rpos_ff) ? epos_ff - rpos_ff : rpos_ff - epos_ff;

      if (cmd.load) begin
         epos_in  = req_entry_position;
         tval_in  = req_time_value;
         ctime_in = req_current_time;
         rpos_in  = req_reference_position;
      end

      // First segment: from the oldest entry to the end of the ring when it
      // wraps, else to the write pointer.
      if (cmd.seg_first) begin
         a_in       = SW'(read_ff) - SW'(1);
         wrapped_in = (read_ff > write_ff);
         hi_in      = (read_ff > write_ff) ? SW'(RING_DEPTH) : SW'(write_ff);
         b_in       = hi_in;
      end

      if (cmd.seg_second) begin
         a_in       = '1;
         hi_in      = SW'(write_ff);
         b_in       = SW'(write_ff);
         wrapped_in = 1'b0;
      end

      if (cmd.probe) begin
         c_in = mid;
      end

      // The probed entry's position rides along with its time, so a hit
      // needs no extra read.
      if (cmd.step) begin
         if (rd_time < tval_ff) begin
            a_in = SW'(c_ff);
         end else begin
            b_in   = SW'(c_ff);
            pos_in = rd_pos;
         end
      end

      if (cmd.commit && push_ok) begin
         write_in = write_next;
         if (write_next == read_ff) begin
            read_in = read_next;
         end
      end

      if (cmd.clear) begin
         read_in  = '0;
         write_in = '0;
      end

      case (cmd.rsp)
         btprl_pkg::RSP_PUSH: begin
            rsp_acc_in = push_ok;
         end
         btprl_pkg::RSP_LOOKUP: begin
            rsp_found_in = hit;
            rsp_fpos_in  = hit ? pos_ff : '0;
         end
         default: begin
            rsp_acc_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff      <= '0;
         write_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         read_ff      <= read_in;
         write_ff     <= write_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      epos_ff      <= epos_in;
      tval_ff      <= tval_in;
      ctime_ff     <= ctime_in;
      rpos_ff      <= rpos_in;
      tdiff_ff     <= tdiff_in;
      pdiff_ff     <= pdiff_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      hi_ff        <= hi_in;
      wrapped_ff   <= wrapped_in;
      c_ff         <= c_in;
      pos_ff       <= pos_in;
      rsp_fpos_ff  <= rsp_fpos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   btprl_ram #(
      .WIDTH (MW),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({epos_ff, tval_ff}),
      .rdata (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_accepted       = rsp_acc_ff;

endmodule

`default_nettype wire

FILE: rtl/binlog_time_position_ring_lookup_top.sv
`default_nettype none

// Time/position ring with lookup. A transaction is taken when start is high
// and busy is low; its result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, and must be captured then because the receiver cannot
// hold it off. Every transaction gives exactly one result. A clear or an
// unknown command answers in the cycle after it is taken and leaves busy low.
// A push registers the inputs, then forms the two distances, and then checks
// the windows and writes the ring. A lookup runs a binary search over the one
// or two wrapped segments, moving on to the second segment when the first
// misses; a segment of n pairs takes at most ceil(log2(n + 1)) probes. Each
// probe issues an address on the single ring RAM port and compares the
// registered read data in the next cycle. The ring holds at most
// RING_DEPTH - 1 pairs and needs no clearing pass after reset. The windows
// are written over the APB port at byte addresses 0 (time window, 48 bits)
// and 8 (position window, 32 bits); the user must write them only while no
// transaction is in flight, as the block itself does not enforce this.

module binlog_time_position_ring_lookup_top #(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   // Command channel.
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [btprl_pkg::CMD_W-1:0]          req_command,
   input  wire logic [btprl_pkg::POS_W-1:0]          req_entry_position,
   input  wire logic [btprl_pkg::TIME_W-1:0]         req_time_value,
   input  wire logic [btprl_pkg::TIME_W-1:0]         req_current_time,
   input  wire logic [btprl_pkg::POS_W-1:0]          req_reference_position,

   // Result channel.
   output logic                                      rsp_valid,
   output logic      [btprl_pkg::POS_W-1:0]          rsp_found_position,
   output logic                                      rsp_found,
   output logic                                      rsp_accepted,

   // Configuration port.
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [btprl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [btprl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [btprl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                      pready
);

   btprl_pkg::dp_cmd_type        dp_cmd;
   btprl_pkg::dp_status_type     dp_status;
   logic [btprl_pkg::TWIN_W-1:0] time_window;
   logic [btprl_pkg::PWIN_W-1:0] position_window;

   // Window registers behind the APB port.
   btprl_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .time_window     (time_window),
      .position_window (position_window)
   );

   // The sequencer decodes each command and steps the search; it sees the
   // datapath only through the command and status structs.
   btprl_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .status  (dp_status),
      .cmd     (dp_cmd),
      .busy    (busy)
   );

   // Ring pointers, search bounds, window checks, ring RAM and result
   // registers.
   btprl_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (dp_cmd),
      .status                 (dp_status),
      .req_entry_position     (req_entry_position),
      .req_time_value         (req_time_value),
      .req_current_time       (req_current_time),
      .req_reference_position (req_reference_position),
      .time_window            (time_window),
      .position_window        (position_window),
      .rsp_valid              (rsp_valid),
      .rsp_found_position     (rsp_found_position),
      .rsp_found              (rsp_found),
      .rsp_accepted           (rsp_accepted)
   );

endmodule

`default_nettype wire
